### rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion that is switched off while reset is asserted (active low)
`define SPSG_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (prop)) \
    else $error("assertion failed");

// assertion that is also checked during reset
`define SPSG_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) (prop)) \
    else $error("assertion failed");

`endif

### rtl/core/spsg_pkg.sv
// shared constants for the stepper step generator
`timescale 1ns / 1ps

package spsg_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_MM_SCALE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_FLOOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_CEILING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT  = 3'd6;

  // register widths
  localparam int STEPS_W = 16;
  localparam int GAIN_W  = 10;
  localparam int HZ_W    = 16;
  localparam int PULSE_W = 10;
  localparam int LOWER_W = 20;
  localparam int UPPER_W = 19;

  // register reset values
  localparam logic [STEPS_W-1:0]        STEPS_RST   = 16'd1600;
  localparam logic [GAIN_W-1:0]         GAIN_RST    = 10'd10;
  localparam logic [HZ_W-1:0]           FLOOR_RST   = 16'd20;
  localparam logic [HZ_W-1:0]           CEILING_RST = 16'd2000;
  localparam logic [PULSE_W-1:0]        PULSE_RST   = 10'd4;
  localparam logic signed [LOWER_W-1:0] LOWER_RST   = -20'sd160000;
  localparam logic [UPPER_W-1:0]        UPPER_RST   = 19'd160000;

  // opcodes
  localparam logic OP_SERVICE = 1'b0;
  localparam logic OP_MOVE    = 1'b1;

  // move offset and rounding
  localparam int MOVE_W      = 17;
  localparam int MOVE_PROD_W = MOVE_W + STEPS_W;
  localparam int ROUND_SHIFT = 8;
  localparam int ROUND_BIAS  = 128;
  localparam int Q_W         = MOVE_PROD_W + 1 - ROUND_SHIFT;

  // half period division: one second in microseconds over twice the rate
  localparam int NUM_W = 20;
  localparam int DEN_W = HZ_W + 1;
  localparam logic [NUM_W-1:0] HALF_NUM = 20'd1000000;

endpackage

### rtl/core/spsg_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module spsg_mul #(
  parameter int A_W = 17,
  parameter int B_W = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] prod
);

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   a_r;
  logic [P_W-1:0]   acc_r;
  logic [P_W-1:0]   acc_nxt;
  logic [A_W:0]     part;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  always_comb begin
    part    = {1'b0, acc_r[P_W-1:B_W]} + (acc_r[0] ? {1'b0, a_r} : {(A_W+1){1'b0}});
    acc_nxt = {part, acc_r[B_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(B_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      acc_r <= {{A_W{1'b0}}, b};
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### rtl/core/spsg_div.sv
// restoring divider for the half period, one quotient bit per cycle
`timescale 1ns / 1ps

module spsg_div
  import spsg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] rem_nxt;
  logic [NUM_W-1:0] quo_r;
  logic [NUM_W-1:0] quo_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    diff    = trial - {1'b0, den_r};
    fits    = trial >= {1'b0, den_r};
    rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      quo_r <= HALF_NUM;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### rtl/core/stepper_position_step_generator.sv
// Stepper STEP/DIR generator: one input beat in, one status beat out. A move beat
// (tuser 1) scales its Q8 millimetre offset by the microsteps-per-millimetre setting on a
// bit-serial multiplier, rounds, adds it to the position and clamps it to the soft
// limits and the position range. A service beat (tuser 0) with the driver enabled and
// the target not reached runs the error times the gain through the same multiplier,
// then one second over twice the clamped rate through a restoring divider, and toggles
// STEP once the elapsed time reaches the half period; the divider is skipped when the
// clamped rate is zero. A service beat with the driver disabled or at the target uses
// neither unit. One beat is worked on at a time; the next beat is taken while a finished
// status beat waits in the output register, and a status beat held back by out_tready
// stalls the block until it is taken.
`timescale 1ns / 1ps

module stepper_position_step_generator
  import spsg_pkg::*;
#(
  parameter int POSITION_BITS = 20,
  parameter int TIME_BITS     = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration
  input  logic                                   cfg_we,
  input  logic [CFG_IDX_W-1:0]                   cfg_index,
  input  logic [CFG_DATA_W-1:0]                  cfg_wdata,
  // input beats
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic                                   in_tuser,  // opcode
  // now_us, driver_enabled, move_mm
  input  logic [((TIME_BITS+25)/8)*8-1:0]        in_tdata,
  // result beats
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // step_level, dir_level, position_steps, target_steps, at_target
  output logic [((2*POSITION_BITS+10)/8)*8-1:0]  out_tdata
);

  localparam int PB        = POSITION_BITS;
  localparam int OUT_W     = 2 * PB + 3;
  localparam int OUT_TD_W  = ((2 * PB + 10) / 8) * 8;
  localparam int MA_W      = (PB + 1 > MOVE_W) ? PB + 1 : MOVE_W;
  localparam int MP_W      = MA_W + STEPS_W;
  localparam int SUM_W     = ((PB > Q_W + 1) ? PB : Q_W + 1) + 1;
  localparam int HALF_W    = (TIME_BITS > NUM_W) ? TIME_BITS : NUM_W;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MUL  = 9'b000000010,
    ST_SUM  = 9'b000000100,
    ST_LIM  = 9'b000001000,
    ST_SAT  = 9'b000010000,
    ST_RATE = 9'b000100000,
    ST_DIV  = 9'b001000000,
    ST_EDGE = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  state_t state_r;

  // configuration registers
  logic [STEPS_W-1:0]        steps_r;
  logic [GAIN_W-1:0]         gain_r;
  logic [HZ_W-1:0]           floor_r;
  logic [HZ_W-1:0]           ceil_r;
  logic [PULSE_W-1:0]        pulse_r;
  logic signed [LOWER_W-1:0] lower_r;
  logic [UPPER_W-1:0]        upper_r;

  // block state
  logic signed [PB-1:0]      pos_r;
  logic signed [PB-1:0]      tgt_r;
  logic                      phase_r;
  logic                      step_r;
  logic                      dir_r;
  logic [TIME_BITS-1:0]      last_r;

  // per-beat working registers
  logic                      op_r;
  logic [TIME_BITS-1:0]      now_r;
  logic                      neg_r;
  logic                      fwd_r;
  logic [Q_W-1:0]            q_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [HZ_W-1:0]           rate_r;
  logic [HALF_W-1:0]         half_r;

  // output register
  logic                      out_tvalid_r;
  logic [OUT_W-1:0]          out_data_r;

  // input unpacking
  logic                      in_acc;
  logic [TIME_BITS-1:0]      in_now;
  logic                      in_en;
  logic signed [MOVE_W-1:0]  in_move;
  logic [MOVE_W-1:0]         move_mag;

  // error
  logic [PB:0]               err_fw;
  logic [PB:0]               err_bw;
  logic                      err_neg;
  logic [PB:0]               err_mag;
  logic                      at_tgt;

  // multiplier, shared by both opcodes, and divider
  logic                      mul_start;
  logic [MA_W-1:0]           mul_a;
  logic [STEPS_W-1:0]        mul_b;
  logic                      mul_done;
  logic [MP_W-1:0]           mul_prod;
  logic                      div_start;
  logic                      div_done;
  logic [NUM_W-1:0]          div_quo;

  // next values
  logic [MOVE_PROD_W:0]      rnd;
  logic [Q_W-1:0]            q_nxt;
  logic [MP_W-1:0]           rate_lo;
  logic [HZ_W-1:0]           rate_nxt;
  logic [NUM_W-1:0]          half_q;
  logic [HALF_W-1:0]         half_nxt;
  logic signed [SUM_W-1:0]   pos_ext;
  logic signed [SUM_W-1:0]   q_ext;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic signed [SUM_W-1:0]   lower_ext;
  logic signed [SUM_W-1:0]   upper_ext;
  logic signed [SUM_W-1:0]   lim_lo;
  logic signed [SUM_W-1:0]   lim_nxt;
  logic signed [SUM_W-1:0]   pos_max_ext;
  logic signed [SUM_W-1:0]   pos_min_ext;
  logic signed [SUM_W-1:0]   sat_nxt;
  logic [TIME_BITS-1:0]      elapsed;
  logic                      out_free;

  assign in_acc   = in_tvalid && in_tready;
  assign in_now   = in_tdata[TIME_BITS-1:0];
  assign in_en    = in_tdata[TIME_BITS];
  assign in_move  = $signed(in_tdata[TIME_BITS+MOVE_W:TIME_BITS+1]);
  assign move_mag = in_move[MOVE_W-1] ? MOVE_W'(-in_move) : in_move;

  always_comb begin
    err_fw  = {tgt_r[PB-1], tgt_r} - {pos_r[PB-1], pos_r};
    err_bw  = {pos_r[PB-1], pos_r} - {tgt_r[PB-1], tgt_r};
    err_neg = err_fw[PB];
    err_mag = err_neg ? err_bw : err_fw;
    at_tgt  = (tgt_r == pos_r);
  end

  assign mul_start = in_acc && ((in_tuser == OP_MOVE) || (in_en && !at_tgt));
  assign mul_a     = (in_tuser == OP_MOVE) ? MA_W'(move_mag) : MA_W'(err_mag);
  assign mul_b     = (in_tuser == OP_MOVE) ? steps_r : STEPS_W'(gain_r);
  assign div_start = (state_r == ST_RATE) && (rate_r != '0);

  spsg_mul #(
    .A_W (MA_W),
    .B_W (STEPS_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  spsg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .den   ({rate_r, 1'b0}),
    .done  (div_done),
    .quo   (div_quo)
  );

  // rounding, rate clamp and half period
  always_comb begin
    rnd      = {1'b0, mul_prod[MOVE_PROD_W-1:0]} + (MOVE_PROD_W+1)'(ROUND_BIAS);
    q_nxt    = rnd[MOVE_PROD_W:ROUND_SHIFT];
    rate_lo  = (mul_prod < MP_W'(floor_r)) ? MP_W'(floor_r) : mul_prod;
    rate_nxt = (rate_lo > MP_W'(ceil_r)) ? ceil_r : rate_lo[HZ_W-1:0];
    half_q   = (div_quo < NUM_W'(pulse_r)) ? NUM_W'(pulse_r) : div_quo;
    half_nxt = HALF_W'(half_q);
  end

  // target arithmetic
  always_comb begin
    pos_ext     = {{(SUM_W-PB){pos_r[PB-1]}}, pos_r};
    q_ext       = {{(SUM_W-Q_W){1'b0}}, q_r};
    sum_nxt     = neg_r ? (pos_ext - q_ext) : (pos_ext + q_ext);
    lower_ext   = {{(SUM_W-LOWER_W){lower_r[LOWER_W-1]}}, lower_r};
    upper_ext   = {{(SUM_W-UPPER_W){1'b0}}, upper_r};
    lim_lo      = (sum_r < lower_ext) ? lower_ext : sum_r;
    lim_nxt     = (lim_lo > upper_ext) ? upper_ext : lim_lo;
    pos_max_ext = {{(SUM_W-PB+1){1'b0}}, {(PB-1){1'b1}}};
    pos_min_ext = {{(SUM_W-PB+1){1'b1}}, {(PB-1){1'b0}}};
    if (sum_r < pos_min_ext) begin
      sat_nxt = pos_min_ext;
    end else if (sum_r > pos_max_ext) begin
      sat_nxt = pos_max_ext;
    end else begin
      sat_nxt = sum_r;
    end
  end

  assign elapsed  = now_r - last_r;
  assign out_free = !out_tvalid_r || out_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= STEPS_RST;
      gain_r  <= GAIN_RST;
      floor_r <= FLOOR_RST;
      ceil_r  <= CEILING_RST;
      pulse_r <= PULSE_RST;
      lower_r <= LOWER_RST;
      upper_r <= UPPER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MM_SCALE:     steps_r <= cfg_wdata[STEPS_W-1:0];
        CFG_SPEED_GAIN:   gain_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_RATE_FLOOR:   floor_r <= cfg_wdata[HZ_W-1:0];
        CFG_RATE_CEILING: ceil_r  <= cfg_wdata[HZ_W-1:0];
        CFG_MIN_PULSE:    pulse_r <= cfg_wdata[PULSE_W-1:0];
        CFG_LOWER_LIMIT:  lower_r <= $signed(cfg_wdata[LOWER_W-1:0]);
        CFG_UPPER_LIMIT:  upper_r <= cfg_wdata[UPPER_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= '0;
      tgt_r        <= '0;
      phase_r      <= 1'b0;
      step_r       <= 1'b0;
      dir_r        <= 1'b1;
      last_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if ((state_r == ST_DONE) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_tuser == OP_MOVE) begin
              state_r <= ST_MUL;
            end else if (in_en && !at_tgt) begin
              dir_r   <= err_neg;
              state_r <= ST_MUL;
            end else begin
              phase_r <= 1'b0;
              state_r <= ST_DONE;
            end
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state_r <= (op_r == OP_MOVE) ? ST_SUM : ST_RATE;
          end
        end
        ST_SUM:  state_r <= ST_LIM;
        ST_LIM:  state_r <= ST_SAT;
        ST_SAT: begin
          tgt_r   <= sat_nxt[PB-1:0];
          state_r <= ST_DONE;
        end
        ST_RATE: state_r <= (rate_r == '0) ? ST_EDGE : ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_EDGE;
          end
        end
        ST_EDGE: begin
          if (HALF_W'(elapsed) >= half_r) begin
            last_r <= now_r;
            if (!phase_r) begin
              step_r  <= 1'b1;
              phase_r <= 1'b1;
            end else begin
              step_r  <= 1'b0;
              phase_r <= 1'b0;
              pos_r   <= fwd_r ? pos_r + 1'b1 : pos_r - 1'b1;
            end
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tuser;
      now_r <= in_now;
      neg_r <= in_move[MOVE_W-1];
      fwd_r <= !err_neg;
    end
    if ((state_r == ST_MUL) && mul_done) begin
      q_r    <= q_nxt;
      rate_r <= rate_nxt;
    end
    if (state_r == ST_SUM) begin
      sum_r <= sum_nxt;
    end else if (state_r == ST_LIM) begin
      sum_r <= lim_nxt;
    end
    if (state_r == ST_RATE) begin
      half_r <= HALF_W'({TIME_BITS{1'b1}});
    end else if ((state_r == ST_DIV) && div_done) begin
      half_r <= half_nxt;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_data_r <= {at_tgt, tgt_r, pos_r, dir_r, step_r};
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TD_W'(out_data_r);

endmodule

### rtl/core/spsg_checker.sv
// port-level checker for the stepper step generator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spsg_checker #(
  parameter int POSITION_BITS = 20,
  parameter int TIME_BITS     = 32
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tvalid,
  input logic                                  in_tready,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [((2*POSITION_BITS+10)/8)*8-1:0] out_tdata
);

  localparam int PB = POSITION_BITS;

  logic at_flag;
  logic pos_eq;

  assign at_flag = out_tdata[2*PB+2];
  assign pos_eq  = (out_tdata[PB+1:2] == out_tdata[2*PB+1:PB+2]);

  // at_target agrees with the two positions of the same beat
  `SPSG_ASSERT(a_at_target, clk, rst_n, out_tvalid |-> (at_flag == pos_eq))

  // one beat in work at a time
  `SPSG_ASSERT(a_one_beat, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready)

  // reset leaves the block empty and ready
  `SPSG_ASSERT_ALWAYS(a_reset, clk, !rst_n |=> (!out_tvalid && in_tready))

  // a stalled result beat holds
  `SPSG_ASSERT(a_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))

endmodule

bind stepper_position_step_generator spsg_checker #(
  .POSITION_BITS (POSITION_BITS),
  .TIME_BITS     (TIME_BITS)
) u_spsg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### verif/tb_top.sv
// self-checking bench for the stepper step generator: random stream stimulus and a scoreboard
`timescale 1ns / 1ps

module tb_top;
  import spsg_pkg::*;

  typedef struct packed {
    bit              at_target;
    bit signed [19:0] target_steps;
    bit signed [19:0] position_steps;
    bit              dir_level;
    bit              step_level;
  } status_t;

  class motion_scoreboard;
    longint mm_scale, speed_gain, rate_floor, rate_ceiling, min_pulse;
    longint lower_limit, upper_limit;
    bit signed [19:0] position, target;
    bit phase, step_lv, dir_lv;
    bit [31:0] last_edge_us;
    status_t expected_status_q[$];
    int mismatches;

    function new();
      mm_scale     = STEPS_RST;
      speed_gain   = GAIN_RST;
      rate_floor   = FLOOR_RST;
      rate_ceiling = CEILING_RST;
      min_pulse    = PULSE_RST;
      lower_limit  = -160000;
      upper_limit  = UPPER_RST;
      position     = '0;
      target       = '0;
      phase        = 1'b0;
      step_lv      = 1'b0;
      dir_lv       = 1'b1;
      last_edge_us = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MM_SCALE:     mm_scale     = val[15:0];
        CFG_SPEED_GAIN:   speed_gain   = val[9:0];
        CFG_RATE_FLOOR:   rate_floor   = val[15:0];
        CFG_RATE_CEILING: rate_ceiling = val[15:0];
        CFG_MIN_PULSE:    min_pulse    = val[9:0];
        CFG_LOWER_LIMIT:  lower_limit  = longint'($signed(val[19:0]));
        CFG_UPPER_LIMIT:  upper_limit  = val[18:0];
        default: ;
      endcase
    endfunction

    // half period in us for the present position error
    function longint half_period();
      longint err, rate, half;
      err = longint'(target) - longint'(position);
      if (err < 0) err = -err;
      rate = speed_gain * err;
      if (rate < rate_floor) rate = rate_floor;
      if (rate > rate_ceiling) rate = rate_ceiling;
      half = (rate != 0) ? 1000000 / (2 * rate) : 64'hFFFF_FFFF;
      if (half < min_pulse) half = min_pulse;
      return half;
    endfunction

    function void log_command(bit op, bit [31:0] now_us, bit enabled, bit signed [16:0] move_mm);
      longint prod, mag, q, desired, err;
      bit [31:0] elapsed;
      status_t st;
      if (op == OP_MOVE) begin
        prod = longint'(move_mm) * mm_scale;
        mag = (prod < 0) ? -prod : prod;
        q = (mag + 128) >>> 8;
        desired = longint'(position) + ((prod < 0) ? -q : q);
        if (desired < lower_limit) desired = lower_limit;
        if (desired > upper_limit) desired = upper_limit;
        if (desired < -524288) desired = -524288;
        if (desired > 524287) desired = 524287;
        target = desired[19:0];
      end else begin
        err = longint'(target) - longint'(position);
        if (!enabled || err == 0) begin
          phase = 1'b0;
        end else begin
          dir_lv = (err < 0);
          elapsed = now_us - last_edge_us;
          if (longint'(elapsed) >= half_period()) begin
            last_edge_us = now_us;
            if (!phase) begin
              step_lv = 1'b1;
              phase = 1'b1;
            end else begin
              step_lv = 1'b0;
              phase = 1'b0;
              position = (err > 0) ? position + 20'sd1 : position - 20'sd1;
            end
          end
        end
      end
      st.step_level     = step_lv;
      st.dir_level      = dir_lv;
      st.position_steps = position;
      st.target_steps   = target;
      st.at_target      = (position == target);
      expected_status_q.push_back(st);
    endfunction

    function void check_status(logic [47:0] data);
      status_t got, exp_st;
      got = status_t'(data[42:0]);
      if (expected_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("status beat with nothing pending: %h", got);
        return;
      end
      exp_st = expected_status_q.pop_front();
      if (got.step_level !== exp_st.step_level || got.dir_level !== exp_st.dir_level ||
          got.position_steps !== exp_st.position_steps ||
          got.target_steps !== exp_st.target_steps || got.at_target !== exp_st.at_target) begin
        mismatches++;
        if (mismatches <= 10)
          $display("status beat differs: exp step %0d dir %0d pos %0d tgt %0d at %0d, got step %0d dir %0d pos %0d tgt %0d at %0d",
                   exp_st.step_level, exp_st.dir_level, exp_st.position_steps,
                   exp_st.target_steps, exp_st.at_target, got.step_level, got.dir_level,
                   got.position_steps, got.target_steps, got.at_target);
      end
    endfunction

    function int pending();
      return expected_status_q.size();
    endfunction
  endclass

  localparam logic [CFG_IDX_W-1:0] REG_ORDER [7] = '{CFG_MM_SCALE, CFG_SPEED_GAIN,
    CFG_RATE_FLOOR, CFG_RATE_CEILING, CFG_MIN_PULSE, CFG_LOWER_LIMIT, CFG_UPPER_LIMIT};

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic                  in_tuser   = 1'b0;
  logic [55:0]           in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [47:0]           out_tdata;

  motion_scoreboard sb = new();
  bit        calm = 1'b0;
  bit [31:0] clock_us = '0;

  stepper_position_step_generator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 22);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_status(out_tdata);
  end

  task automatic send_beat(bit op, bit [31:0] now_us, bit enabled, bit [16:0] move_mm);
    if (!calm && $urandom_range(0, 99) < 22) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, move_mm, enabled, now_us};
    do @(posedge clk); while (!in_tready);
    sb.log_command(op, now_us, enabled, move_mm);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic load_settings(logic [CFG_DATA_W-1:0] vals [7]);
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_wdata <= vals[i];
      sb.write_reg(REG_ORDER[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // mostly enabled service ticks paced near the half period, with small moves and noise
  task automatic run_random(int n);
    int r, sel, lim, mv;
    longint hp;
    bit [31:0] step_us;
    lim = int'((40 * 256) / sb.mm_scale);
    if (lim < 1) lim = 1;
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 2) && (i < n / 2 + 40);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        mv = int'($urandom_range(0, 2 * lim)) - lim;
        send_beat(OP_MOVE, $urandom, 1'($urandom_range(0, 1)), mv[16:0]);
      end else if (r < 11) begin
        send_beat(OP_MOVE, $urandom, 1'($urandom_range(0, 1)), 17'($urandom));
      end else if (r < 14) begin
        send_beat(OP_SERVICE, $urandom, 1'($urandom_range(0, 1)), 17'($urandom));
      end else begin
        hp = sb.half_period();
        sel = $urandom_range(0, 9);
        if (sel < 3) step_us = $urandom_range(0, hp[31:0]);
        else if (sel < 9) step_us = hp[31:0] + $urandom_range(0, hp[31:0] / 4);
        else step_us = $urandom;
        clock_us += step_us;
        send_beat(OP_SERVICE, clock_us, (r >= 20), 17'($urandom));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    bit [31:0] t;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults after reset: ignored fields, clamps, rounding, wrap of the time
    send_beat(OP_SERVICE, 32'd0, 1'b0, 17'h1FFFF);
    send_beat(OP_SERVICE, 32'd100, 1'b1, 17'h0);
    send_beat(OP_MOVE, 32'hFFFF_FFFF, 1'b1, 17'h0FFFF);
    send_beat(OP_MOVE, 32'h0, 1'b0, 17'h10000);
    send_beat(OP_MOVE, 32'h0, 1'b0, 17'd0);
    send_beat(OP_MOVE, 32'h0, 1'b0, 17'd2);
    send_beat(OP_MOVE, 32'h0, 1'b0, -17'sd2);
    send_beat(OP_MOVE, 32'h0, 1'b0, 17'd1);
    send_beat(OP_SERVICE, 32'hFFFF_FFF0, 1'b1, 17'h0);
    send_beat(OP_SERVICE, 32'h10, 1'b1, 17'h0);
    send_beat(OP_SERVICE, 32'h20, 1'b0, 17'h1FFFF);
    t = 32'h10 + 32'd8333;
    send_beat(OP_SERVICE, t, 1'b1, 17'h0);
    t += 32'd8333;
    send_beat(OP_SERVICE, t, 1'b1, 17'h0);
    send_beat(OP_MOVE, t, 1'b1, -17'sd1);
    t += 32'd20000;
    send_beat(OP_SERVICE, t, 1'b1, 17'h0);
    t += 32'd20000;
    send_beat(OP_SERVICE, t, 1'b1, 17'h0);
    clock_us = t;
    run_random(150);
    drain();

    // fast gain, half period held up by the pulse width, full limits
    load_settings('{20'd1, 20'd1023, 20'd1, 20'd65535, 20'd1023, 20'h80000, 20'd524287});
    run_random(150);
    drain();

    // floor above ceiling, no pulse width minimum, narrow limits
    load_settings('{20'd65535, 20'd1, 20'd65535, 20'd1, 20'd0, -20'sd1000, 20'd1000});
    send_beat(OP_MOVE, 32'h0, 1'b0, 17'h0FFFF);
    run_random(120);
    drain();

    // lower limit above the upper one
    load_settings('{20'd300, 20'd50, 20'd100, 20'd5000, 20'd0, 20'd2000, 20'd500});
    send_beat(OP_MOVE, 32'h0, 1'b0, 17'h10000);
    run_random(120);
    drain();

    // zero ceiling: half period is the full time range
    load_settings('{20'd256, 20'd0, 20'd0, 20'd0, 20'd7, -20'sd50, 20'd50});
    send_beat(OP_MOVE, 32'h0, 1'b0, 17'd1);
    t = sb.last_edge_us + 32'hFFFF_FFFE;
    send_beat(OP_SERVICE, t, 1'b1, 17'h0);
    t = sb.last_edge_us + 32'hFFFF_FFFF;
    send_beat(OP_SERVICE, t, 1'b1, 17'h0);
    t = sb.last_edge_us + 32'hFFFF_FFFF;
    send_beat(OP_SERVICE, t, 1'b1, 17'h0);
    clock_us = t;
    run_random(40);
    drain();

    load_settings('{20'd25600, 20'd200, 20'd500, 20'd20000, 20'd10, 20'h80000, 20'd0});
    run_random(180);
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/spsg_pkg.sv
rtl/core/spsg_mul.sv
rtl/core/spsg_div.sv
rtl/core/stepper_position_step_generator.sv
rtl/core/spsg_checker.sv
verif/tb_top.sv
